FILE: hdl/i2c_lux_sensor_reader_defines.svh
// assertion macros used by the light sensor reader checker
`ifndef I2C_LUX_SENSOR_READER_DEFINES_SVH
`define I2C_LUX_SENSOR_READER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ILSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ILSR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ilsr_pkg.sv
// shared types and constants of the light sensor reader
`timescale 1ns / 1ps

package ilsr_pkg;

    // bytes read from the sensor per request, the first four form the count
    localparam int READ_BYTES = 5;
    localparam int RAW_BYTES  = 4;
    localparam int RAW_IDX_W  = 2;

    // sensor register that holds the illuminance count
    localparam logic [7:0] SENSOR_REG = 8'h00;

    // field widths
    localparam int RAW_W   = 32;
    localparam int MILLI_W = 33;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_WAIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_HOLD  = 2'd3;

    // configuration reset values
    localparam logic [7:0] RST_SLAVE_ADDR = 8'd148;
    localparam logic [7:0] RST_PHASE      = 8'd5;
    localparam logic [9:0] RST_READ_WAIT  = 10'd50;
    localparam logic [9:0] RST_STOP_HOLD  = 10'd180;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;

    // divide by five: 16-bit digits, reciprocal (2^22 + 1) / 5, exact below 2^22
    localparam int DIGIT_W    = 16;
    localparam int DIV_V_W    = DIGIT_W + 3;
    localparam int DIV5_SHIFT = 22;
    localparam int DIV5_K_W   = 20;
    localparam int PROD_W     = DIV_V_W + DIV5_K_W;
    localparam logic [DIV5_K_W-1:0] DIV5_K = 20'd838861;

    // register stages from request to result
    localparam int PIPE_DEPTH = 5;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] slave_write_address;
        logic [7:0] phase_ticks;
        logic [9:0] read_wait_ticks;
        logic [9:0] stop_hold_ticks;
    } cfg_t;

    // per-tick result of the sequencer
    typedef struct packed {
        logic [RAW_W-1:0] raw_count;
        logic             done_res;
        logic             busy_res;
        logic             sda_level;
        logic             scl_level;
    } tick_res_t;

    // full result with the scaled value
    typedef struct packed {
        logic [MILLI_W-1:0] milli_lux;
        tick_res_t          base;
    } scaled_res_t;

endpackage

FILE: hdl/ilsr_seq.sv
// bus sequencer: one tick per request, drives the clock and data levels
`timescale 1ns / 1ps

module ilsr_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ilsr_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  start_request,
    input  logic                  sda_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ilsr_pkg::tick_res_t   out_res
);

    typedef enum logic [15:0] {
        SEQ_IDLE    = 16'h0001,
        SEQ_ST_A    = 16'h0002,
        SEQ_ST_B    = 16'h0004,
        SEQ_TX_LO   = 16'h0008,
        SEQ_TX_HI   = 16'h0010,
        SEQ_TX_TAIL = 16'h0020,
        SEQ_TXACK_A = 16'h0040,
        SEQ_TXACK_B = 16'h0080,
        SEQ_WAIT    = 16'h0100,
        SEQ_RX_HI   = 16'h0200,
        SEQ_RX_LO   = 16'h0400,
        SEQ_ACK_HI  = 16'h0800,
        SEQ_ACK_LO  = 16'h1000,
        SEQ_SP_A    = 16'h2000,
        SEQ_SP_B    = 16'h4000,
        SEQ_HOLD    = 16'h8000
    } state_t;

    state_t                      step_reg, step_next, step_cur;
    logic [9:0]                  tick_reg, tick_next, tick_cur;
    logic [3:0]                  bit_reg, bit_next, bit_cur;
    logic [2:0]                  byte_reg, byte_next, byte_cur;
    logic [7:0]                  shreg_reg, shreg_next;
    logic [ilsr_pkg::RAW_W-1:0]  raw_reg, raw_next;
    logic [7:0]                  rx_bytes_reg [ilsr_pkg::RAW_BYTES];
    logic                        rx_we;
    logic                        valid_reg;
    ilsr_pkg::tick_res_t         res_reg, res_next;
    logic [9:0]                  phase_len;
    logic                        phase_end;
    logic                        last_byte;
    logic                        accept;

    // byte sent for the current byte count: write address, register, read address
    function automatic logic [7:0] tx_byte(input logic [2:0] cnt, input logic [7:0] addr);
        logic [7:0] val;
        if (cnt == 3'd0)
        begin
            val = addr;
        end
        else if (cnt == 3'd1)
        begin
            val = ilsr_pkg::SENSOR_REG;
        end
        else
        begin
            val = addr + 8'd1;
        end
        return val;
    endfunction

    // result stage handshake
    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // request entry from idle
    always_comb
    begin
        step_cur = step_reg;
        tick_cur = tick_reg;
        byte_cur = byte_reg;
        bit_cur  = bit_reg;
        if (step_reg == SEQ_IDLE && start_request)
        begin
            step_cur = SEQ_ST_A;
            tick_cur = '0;
            byte_cur = '0;
            bit_cur  = '0;
        end
    end

    // phase length and end of phase
    always_comb
    begin
        case (step_cur)
            SEQ_WAIT: phase_len = cfg.read_wait_ticks;
            SEQ_HOLD: phase_len = cfg.stop_hold_ticks;
            default:  phase_len = (cfg.phase_ticks == 8'd0) ? 10'd1 : {2'b00, cfg.phase_ticks};
        endcase
        phase_end = ({1'b0, tick_cur} + 11'd1) >= {1'b0, phase_len};
        last_byte = ({1'b0, byte_cur} + 4'd1) >= 4'(ilsr_pkg::READ_BYTES);
    end

    // line levels and phase advance
    always_comb
    begin
        step_next  = step_cur;
        tick_next  = tick_cur;
        byte_next  = byte_cur;
        bit_next   = bit_cur;
        shreg_next = shreg_reg;
        raw_next   = raw_reg;
        rx_we      = 1'b0;
        res_next.scl_level = 1'b0;
        res_next.sda_level = 1'b1;
        res_next.busy_res  = 1'b0;
        res_next.done_res  = 1'b0;
        if (step_cur != SEQ_IDLE)
        begin
            res_next.busy_res = 1'b1;
            case (step_cur)
                SEQ_ST_A, SEQ_TXACK_A, SEQ_TXACK_B, SEQ_RX_HI, SEQ_SP_B:
                begin
                    res_next.scl_level = 1'b1;
                    res_next.sda_level = 1'b1;
                end
                SEQ_ST_B, SEQ_SP_A:
                begin
                    res_next.scl_level = 1'b1;
                    res_next.sda_level = 1'b0;
                end
                SEQ_TX_LO, SEQ_TX_TAIL:
                begin
                    res_next.scl_level = 1'b0;
                    res_next.sda_level = shreg_reg[7];
                end
                SEQ_TX_HI:
                begin
                    res_next.scl_level = 1'b1;
                    res_next.sda_level = shreg_reg[7];
                end
                SEQ_ACK_HI:
                begin
                    // nak after the last byte, ack otherwise
                    res_next.scl_level = 1'b1;
                    res_next.sda_level = last_byte;
                end
                default:
                begin
                    res_next.scl_level = 1'b0;
                    res_next.sda_level = 1'b1;
                end
            endcase

            if (phase_end)
            begin
                tick_next = '0;
                if (step_cur == SEQ_RX_HI)
                begin
                    shreg_next = {shreg_reg[6:0], sda_in};
                end
                case (step_cur)
                    SEQ_ST_A:    step_next = SEQ_ST_B;
                    SEQ_ST_B:
                    begin
                        shreg_next = tx_byte(byte_cur, cfg.slave_write_address);
                        bit_next   = '0;
                        step_next  = SEQ_TX_LO;
                    end
                    SEQ_TX_LO:   step_next = SEQ_TX_HI;
                    SEQ_TX_HI:   step_next = SEQ_TX_TAIL;
                    SEQ_TX_TAIL:
                    begin
                        shreg_next = {shreg_reg[6:0], 1'b0};
                        bit_next   = bit_cur + 4'd1;
                        step_next  = (bit_cur >= 4'd7) ? SEQ_TXACK_A : SEQ_TX_LO;
                    end
                    SEQ_TXACK_A: step_next = SEQ_TXACK_B;
                    SEQ_TXACK_B:
                    begin
                        if (byte_cur == 3'd0)
                        begin
                            byte_next  = 3'd1;
                            shreg_next = tx_byte(3'd1, cfg.slave_write_address);
                            bit_next   = '0;
                            step_next  = SEQ_TX_LO;
                        end
                        else if (byte_cur == 3'd1)
                        begin
                            // repeated start before the read address
                            byte_next = 3'd2;
                            step_next = SEQ_ST_A;
                        end
                        else
                        begin
                            byte_next  = '0;
                            bit_next   = '0;
                            shreg_next = '0;
                            step_next  = (cfg.read_wait_ticks == 10'd0) ? SEQ_RX_HI : SEQ_WAIT;
                        end
                    end
                    SEQ_WAIT:    step_next = SEQ_RX_HI;
                    SEQ_RX_HI:   step_next = SEQ_RX_LO;
                    SEQ_RX_LO:
                    begin
                        bit_next = bit_cur + 4'd1;
                        if (bit_cur >= 4'd7)
                        begin
                            rx_we     = byte_cur < 3'(ilsr_pkg::RAW_BYTES);
                            step_next = SEQ_ACK_HI;
                        end
                        else
                        begin
                            step_next = SEQ_RX_HI;
                        end
                    end
                    SEQ_ACK_HI:  step_next = SEQ_ACK_LO;
                    SEQ_ACK_LO:
                    begin
                        if (last_byte)
                        begin
                            step_next = SEQ_SP_A;
                        end
                        else
                        begin
                            byte_next  = byte_cur + 3'd1;
                            bit_next   = '0;
                            shreg_next = '0;
                            step_next  = SEQ_RX_HI;
                        end
                    end
                    SEQ_SP_A:    step_next = SEQ_SP_B;
                    SEQ_SP_B, SEQ_HOLD:
                    begin
                        if (step_cur == SEQ_SP_B && cfg.stop_hold_ticks != 10'd0)
                        begin
                            step_next = SEQ_HOLD;
                        end
                        else
                        begin
                            // transaction complete, take the little-endian count
                            raw_next  = {rx_bytes_reg[3], rx_bytes_reg[2],
                                         rx_bytes_reg[1], rx_bytes_reg[0]};
                            step_next = SEQ_IDLE;
                            byte_next = '0;
                            bit_next  = '0;
                            res_next.done_res = 1'b1;
                        end
                    end
                    default:     step_next = SEQ_IDLE;
                endcase
            end
            else
            begin
                tick_next = tick_cur + 10'd1;
            end
        end
        res_next.raw_count = raw_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= SEQ_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            byte_reg  <= '0;
            shreg_reg <= '0;
            raw_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                step_reg  <= step_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                byte_reg  <= byte_next;
                shreg_reg <= shreg_next;
                raw_reg   <= raw_next;
            end
        end
    end

    // received bytes and result payload
    always_ff @(posedge clk)
    begin
        if (accept && rx_we)
        begin
            rx_bytes_reg[byte_cur[ilsr_pkg::RAW_IDX_W-1:0]] <= shreg_next;
        end
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: hdl/ilsr_scale.sv
// count to milli-lux scaler: times seven, then divide by five one digit a stage
`timescale 1ns / 1ps

module ilsr_scale
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ilsr_pkg::tick_res_t   in_res,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ilsr_pkg::scaled_res_t out_res
);

    localparam int Y_W = ilsr_pkg::RAW_W + 3;
    localparam int DW  = ilsr_pkg::DIGIT_W;
    localparam int VW  = ilsr_pkg::DIV_V_W;
    localparam int PW  = ilsr_pkg::PROD_W;
    localparam int SH  = ilsr_pkg::DIV5_SHIFT;

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy2, rdy3, rdy4, rdy5;

    ilsr_pkg::tick_res_t   rec2_reg, rec3_reg, rec4_reg;
    ilsr_pkg::scaled_res_t res5_reg;

    logic [Y_W-1:0] y2_reg;
    logic           q0_3_reg, q0_4_reg;
    logic [DW-1:0]  ylo3_reg;
    logic [VW-1:0]  v1_3_reg;
    logic [PW-1:0]  prod1_3_reg, prod2_4_reg;
    logic [DW-1:0]  q1_4_reg;

    logic [2:0]     top3, r0;
    logic           q0;
    logic [VW-1:0]  v1, v2, five_q1, r1_full;
    logic [DW-1:0]  q1, q2;

    // stage handshake, a stage takes new data when empty or draining
    assign rdy5      = !v5_reg || out_ready;
    assign rdy4      = !v4_reg || rdy5;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign in_ready  = rdy2;
    assign out_valid = v5_reg;
    assign out_res   = res5_reg;

    // top digit, a compare and subtract, then first reciprocal product
    assign top3 = y2_reg[Y_W-1:2*DW];
    assign q0   = top3 >= 3'd5;
    assign r0   = q0 ? (top3 - 3'd5) : top3;
    assign v1   = {r0, y2_reg[2*DW-1:DW]};

    // middle digit remainder and second product operand
    assign q1      = prod1_3_reg[SH +: DW];
    assign five_q1 = {1'b0, q1, 2'b00} + {3'b000, q1};
    assign r1_full = v1_3_reg - five_q1;
    assign v2      = {r1_full[2:0], ylo3_reg};

    // low digit
    assign q2 = prod2_4_reg[SH +: DW];

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= in_valid;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy2 && in_valid)
        begin
            rec2_reg <= in_res;
            y2_reg   <= {in_res.raw_count, 3'b000} - {3'b000, in_res.raw_count};
        end
        if (rdy3 && v2_reg)
        begin
            rec3_reg    <= rec2_reg;
            q0_3_reg    <= q0;
            ylo3_reg    <= y2_reg[DW-1:0];
            v1_3_reg    <= v1;
            prod1_3_reg <= PW'(v1) * PW'(ilsr_pkg::DIV5_K);
        end
        if (rdy4 && v3_reg)
        begin
            rec4_reg    <= rec3_reg;
            q0_4_reg    <= q0_3_reg;
            q1_4_reg    <= q1;
            prod2_4_reg <= PW'(v2) * PW'(ilsr_pkg::DIV5_K);
        end
        if (rdy5 && v4_reg)
        begin
            res5_reg.base      <= rec4_reg;
            res5_reg.milli_lux <= {q0_4_reg, q1_4_reg, q2};
        end
    end

endmodule

FILE: hdl/i2c_lux_sensor_reader.sv
// top level of the light sensor reader: config registers, sequencer and scaler
`timescale 1ns / 1ps

// Light sensor reader, a bit-banged I2C master that reads the illuminance count.
// Input stream: one request per timebase tick, s_axis_tdata holds start_request
// and the sampled data line. Each request yields exactly one result on the
// output stream: clock and data levels to drive, busy, done, the last raw count
// and the count scaled to milli-lux (raw * 7 / 5, truncated).
// A start request while idle begins start, write address, register number,
// repeated start, read address, wait, five received bytes, stop and hold (wait
// and hold skipped when zero); done is set on the last tick of the hold, or of
// the stop without hold, and already carries the new count. One sequencer stage
// and four scaler stages (times seven, then one 16-bit quotient digit per
// multiply) lie between request and result. Throughput is one request per cycle
// unless the receiver stalls; the sequencer advances one tick per request and
// the scaler multipliers are fully pipelined. When the receiver stalls, results
// collect in the stages and s_axis_tready falls only once all five stages hold
// a result. Reset clears the sequencer to idle, the count to zero and the config
// registers to their defaults; cfg writes are taken whenever cfg_wr_en is high.
module i2c_lux_sensor_reader
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] start_request, [1] sda_in, [7:2] zero
    input  logic [ilsr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
    // [35:4] raw_count, [68:36] milli_lux, [71:69] zero
    output logic [ilsr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                               cfg_wr_en,
    input  logic [ilsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ilsr_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    ilsr_pkg::cfg_t        cfg_reg;
    logic                  seq_valid, seq_ready;
    ilsr_pkg::tick_res_t   seq_res;
    ilsr_pkg::scaled_res_t out_res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_write_address <= ilsr_pkg::RST_SLAVE_ADDR;
            cfg_reg.phase_ticks         <= ilsr_pkg::RST_PHASE;
            cfg_reg.read_wait_ticks     <= ilsr_pkg::RST_READ_WAIT;
            cfg_reg.stop_hold_ticks     <= ilsr_pkg::RST_STOP_HOLD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ilsr_pkg::CFG_SLAVE_ADDR: cfg_reg.slave_write_address <= cfg_wr_data[7:0];
                ilsr_pkg::CFG_PHASE:      cfg_reg.phase_ticks         <= cfg_wr_data[7:0];
                ilsr_pkg::CFG_READ_WAIT:  cfg_reg.read_wait_ticks     <= cfg_wr_data[9:0];
                ilsr_pkg::CFG_STOP_HOLD:  cfg_reg.stop_hold_ticks     <= cfg_wr_data[9:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    // bus sequencer
    ilsr_seq u_seq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .start_request (s_axis_tdata[0]),
        .sda_in        (s_axis_tdata[1]),
        .out_valid     (seq_valid),
        .out_ready     (seq_ready),
        .out_res       (seq_res)
    );

    // milli-lux scaler
    ilsr_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seq_valid),
        .in_ready  (seq_ready),
        .in_res    (seq_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // result packing
    assign m_axis_tdata = {3'b000,
                           out_res.milli_lux,
                           out_res.base.raw_count,
                           out_res.base.done_res,
                           out_res.base.busy_res,
                           out_res.base.sda_level,
                           out_res.base.scl_level};

endmodule

FILE: hdl/ilsr_checker.sv
// port-level checks of the light sensor reader, bound to the top level
`timescale 1ns / 1ps
`include "i2c_lux_sensor_reader_defines.svh"

module ilsr_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ilsr_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic                           in_acc, out_acc;
    logic [ilsr_pkg::CNT_W-1:0]     flight_reg;
    logic [ilsr_pkg::RAW_W-1:0]     prev_raw_reg;
    logic [ilsr_pkg::RAW_W-1:0]     raw;
    logic [ilsr_pkg::MILLI_W-1:0]   milli;
    logic                           done;
    logic [35:0]                    raw7, milli5;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign done    = m_axis_tdata[3];
    assign raw     = m_axis_tdata[35:4];
    assign milli   = m_axis_tdata[68:36];
    assign raw7    = {1'b0, raw, 3'b000} - {4'b0000, raw};
    assign milli5  = {1'b0, milli, 2'b00} + {3'b000, milli};

    // requests in flight and last delivered count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg   <= '0;
            prev_raw_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_reg + ilsr_pkg::CNT_W'(in_acc) - ilsr_pkg::CNT_W'(out_acc);
            if (out_acc)
            begin
                prev_raw_reg <= raw;
            end
        end
    end

    `ILSR_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `ILSR_ASSERT_IMP(a_count_on_done, out_acc && raw != prev_raw_reg, done, "count changed without done")
    `ILSR_ASSERT_IMP(a_scale, m_axis_tvalid, milli5 <= raw7 && raw7 < milli5 + 36'd5, "milli-lux is not raw*7/5")
    `ILSR_ASSERT_IMP(a_no_extra, out_acc, flight_reg != '0, "result without a request")
    `ILSR_ASSERT_IMP(a_depth, 1'b1, flight_reg <= ilsr_pkg::CNT_W'(ilsr_pkg::PIPE_DEPTH), "more requests in flight than stages")

endmodule

bind i2c_lux_sensor_reader ilsr_checker u_ilsr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
